@@ rtl/rgg3_pkg.sv @@
// ----------------------------------------------------------------------------
// rgg3_pkg - shared types and constants for the gray conversion / 3x3 blur
// Payload structs, register indexes, fixed-point weights and the divide-by-1000
// helper used by the datapath.
// ----------------------------------------------------------------------------
package rgg3_pkg;

	// Line store geometry
	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);

	// Register widths and reset values
	localparam int WIDTH_W      = 11;
	localparam int HEIGHT_W     = 16;
	localparam int ROW_W        = HEIGHT_W + 1;
	localparam int EFFW_W       = (WIDTH_W > COL_W + 1) ? WIDTH_W : COL_W + 1;
	localparam int WIDTH_RESET  = 512;
	localparam int HEIGHT_RESET = 512;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = HEIGHT_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH,
		CFG_IMAGE_HEIGHT
	} cfg_reg_t;

	// Input command codes
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// Pixel and gray widths
	localparam int PIX_W = 8;
	localparam int LINE_W = 2 * PIX_W;

	// Gray conversion weights (per thousand)
	localparam int GRAY_R = 299;
	localparam int GRAY_G = 587;
	localparam int GRAY_B = 114;

	// Gaussian weights (per thousand)
	localparam int W_CORNER = 45;
	localparam int W_EDGE   = 122;
	localparam int W_CENTER = 332;

	// Rounding offset for the divide by 1000
	localparam int ROUND_HALF = 500;

	// Weighted sums stay at or below 255500: 18 bits
	localparam int SUM_W = 18;

	// x / 1000 == (x * DIV_MULT) >> DIV_SHIFT for x < 493000
	localparam int DIV_SHIFT  = 28;
	localparam int DIV_MULT   = 268436;
	localparam int DIV_MULT_W = 19;
	localparam int PROD_W     = SUM_W + DIV_MULT_W;

	typedef struct packed {
		logic             cmd;
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] filtered;
		logic             row_end;
		logic             frame_end;
	} out_item_t;

	// Taps forced to zero at the image border
	typedef struct packed {
		logic top;
		logic bot;
		logic left;
		logic right;
	} tap_mask_t;

	function automatic logic [PIX_W-1:0] div1000(input logic [SUM_W-1:0] x);
		logic [PROD_W-1:0] p;
		p = PROD_W'(x) * PROD_W'(DIV_MULT);
		return p[DIV_SHIFT+PIX_W-1:DIV_SHIFT];
	endfunction

endpackage

@@ rtl/rgb_gray_gaussian3x3_unit.sv @@
// ----------------------------------------------------------------------------
// rgb_gray_gaussian3x3_unit - RGB to gray conversion and 3x3 Gaussian blur
// Raster-order RGB in, one filtered gray pixel out per centre pixel. Gray
// values live in one line-store memory holding both previous rows per column.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle unless out_stall backs up the pipeline.
//   Line memory read-modify-write once per item, with forwarding for
//   back-to-back same-column hits. Path of the item one row and one pixel
//   after a centre pixel: stage 1, window, stage 3, output register.
// Reset: width and height 512, scan position and window zero. Line memory
//   contents stay undefined; border masking keeps them from being seen.
// ----------------------------------------------------------------------------
module rgb_gray_gaussian3x3_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [rgg3_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rgg3_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  rgg3_pkg::in_item_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output rgg3_pkg::out_item_t                out_data
);

	localparam int PW = rgg3_pkg::PIX_W;
	localparam int SW = rgg3_pkg::SUM_W;

	// Configuration registers
	logic [rgg3_pkg::WIDTH_W-1:0]  width_q;
	logic [rgg3_pkg::HEIGHT_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rgg3_pkg::WIDTH_W'(rgg3_pkg::WIDTH_RESET);
			height_q <= rgg3_pkg::HEIGHT_W'(rgg3_pkg::HEIGHT_RESET);
		end else if (cfg_write) begin
			case (cfg_index)
				rgg3_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data[rgg3_pkg::WIDTH_W-1:0];
				rgg3_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data[rgg3_pkg::HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective frame size
	logic [rgg3_pkg::EFFW_W-1:0] w_eff;
	logic [rgg3_pkg::ROW_W-1:0]  h_eff;
	logic [rgg3_pkg::ROW_W-1:0]  h_plus1;

	always_comb begin
		if (width_q == '0) begin
			w_eff = rgg3_pkg::EFFW_W'(1);
		end else if (rgg3_pkg::EFFW_W'(width_q) > rgg3_pkg::EFFW_W'(rgg3_pkg::MAX_WIDTH)) begin
			w_eff = rgg3_pkg::EFFW_W'(rgg3_pkg::MAX_WIDTH);
		end else begin
			w_eff = rgg3_pkg::EFFW_W'(width_q);
		end
		h_eff   = (height_q == '0) ? rgg3_pkg::ROW_W'(1) : rgg3_pkg::ROW_W'(height_q);
		h_plus1 = h_eff + rgg3_pkg::ROW_W'(1);
	end

	// Pipeline flow control
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic out_free, free3, free2, free1;
	logic move1, move2, move3, accept;

	assign out_free = !out_valid_q || !out_stall;
	assign free3    = !v_s3 || out_free;
	assign move3    = v_s3 && out_free;
	assign free2    = !v_s2 || free3;
	assign move2    = v_s2 && free3;
	assign free1    = !v_s1 || free2;
	assign move1    = v_s1 && free2;
	assign in_stall = !free1;
	assign accept   = in_valid && free1;

	// Scan position and border decode at transfer
	logic [rgg3_pkg::ROW_W-1:0] row_q;
	logic [rgg3_pkg::COL_W-1:0] col_q;
	logic                       last_col, mid_out, wrap_out, have_out;
	rgg3_pkg::tap_mask_t        mask_in;
	logic [SW-1:0]              gray_sum;

	always_comb begin
		last_col = (rgg3_pkg::EFFW_W'(col_q) + rgg3_pkg::EFFW_W'(1)) >= w_eff;
		mid_out  = (col_q != '0) && (row_q != '0);
		wrap_out = (col_q == '0) && (row_q >= rgg3_pkg::ROW_W'(2));
		have_out = mid_out || wrap_out;
		mask_in.top   = mid_out ? (row_q == rgg3_pkg::ROW_W'(1)) : (row_q == rgg3_pkg::ROW_W'(2));
		mask_in.bot   = mid_out ? (row_q >= h_eff) : (row_q >= h_plus1);
		mask_in.left  = mid_out ? (col_q == rgg3_pkg::COL_W'(1)) : (w_eff == rgg3_pkg::EFFW_W'(1));
		mask_in.right = wrap_out;
	end

	// Weighted RGB sum with rounding offset; a flush item is a zero pixel
	always_comb begin
		if (in_data.cmd == rgg3_pkg::CMD_FLUSH) begin
			gray_sum = '0;
		end else begin
			gray_sum = SW'(rgg3_pkg::GRAY_R) * SW'(in_data.red)
			         + SW'(rgg3_pkg::GRAY_G) * SW'(in_data.green)
			         + SW'(rgg3_pkg::GRAY_B) * SW'(in_data.blue)
			         + SW'(rgg3_pkg::ROUND_HALF);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_write) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (wrap_out && mask_in.bot) begin
				row_q <= '0;
				col_q <= '0;
			end else if (last_col) begin
				row_q <= row_q + rgg3_pkg::ROW_W'(1);
				col_q <= '0;
			end else begin
				col_q <= col_q + rgg3_pkg::COL_W'(1);
			end
		end
	end

	// Stage 1 registers
	logic [SW-1:0]                 sum_s1;
	logic [rgg3_pkg::COL_W-1:0]    col_s1;
	logic                          have_s1;
	rgg3_pkg::tap_mask_t           mask_s1;
	logic                          fwd_s1;
	logic [rgg3_pkg::LINE_W-1:0]   fwd_data_s1;
	logic [rgg3_pkg::LINE_W-1:0]   rd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			if (free1) v_s1 <= accept;
			if (accept) fwd_s1 <= move1 && (col_s1 == col_q);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sum_s1  <= gray_sum;
			col_s1  <= col_q;
			have_s1 <= have_out;
			mask_s1 <= mask_in;
		end
	end

	// Stage 1: gray value, line update, window shift
	logic [PW-1:0]               g_s1, above_eff, mid_eff;
	logic [rgg3_pkg::LINE_W-1:0] line_eff, wr_data;

	always_comb begin
		g_s1      = rgg3_pkg::div1000(sum_s1);
		line_eff  = fwd_s1 ? fwd_data_s1 : rd_s1;
		above_eff = line_eff[rgg3_pkg::LINE_W-1:PW];
		mid_eff   = line_eff[PW-1:0];
		wr_data   = {mid_eff, g_s1};
	end

	// Line memory: {row above, middle row} per column, read at transfer
	logic [rgg3_pkg::LINE_W-1:0] line_mem [rgg3_pkg::MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (move1) line_mem[col_s1] <= wr_data;
		if (accept) rd_s1 <= line_mem[col_q];
	end

	// Forward the value being written when the next item hits the same column
	always_ff @(posedge clk) begin
		if (accept) fwd_data_s1 <= wr_data;
	end

	// 3x3 window, row-major, newest column on the right
	logic [PW-1:0] win_q [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else if (move1) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i*3]   <= win_q[i*3+1];
				win_q[i*3+1] <= win_q[i*3+2];
			end
			win_q[2] <= above_eff;
			win_q[5] <= mid_eff;
			win_q[8] <= g_s1;
		end
	end

	// Stage 2: masked taps and weighted sum
	rgg3_pkg::tap_mask_t mask_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (free2) begin
			v_s2 <= v_s1 && have_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move1) mask_s2 <= mask_s1;
	end

	logic [PW-1:0]  t0, t1, t2, t3, t5, t6, t7, t8;
	logic [PW+1:0]  corner_sum, edge_sum;
	logic [SW-1:0]  acc;

	always_comb begin
		t0 = (mask_s2.top || mask_s2.left)  ? '0 : win_q[0];
		t1 = mask_s2.top                    ? '0 : win_q[1];
		t2 = (mask_s2.top || mask_s2.right) ? '0 : win_q[2];
		t3 = mask_s2.left                   ? '0 : win_q[3];
		t5 = mask_s2.right                  ? '0 : win_q[5];
		t6 = (mask_s2.bot || mask_s2.left)  ? '0 : win_q[6];
		t7 = mask_s2.bot                    ? '0 : win_q[7];
		t8 = (mask_s2.bot || mask_s2.right) ? '0 : win_q[8];
		corner_sum = (PW+2)'(t0) + (PW+2)'(t2) + (PW+2)'(t6) + (PW+2)'(t8);
		edge_sum   = (PW+2)'(t1) + (PW+2)'(t3) + (PW+2)'(t5) + (PW+2)'(t7);
		acc = SW'(rgg3_pkg::W_CORNER) * SW'(corner_sum)
		    + SW'(rgg3_pkg::W_EDGE) * SW'(edge_sum)
		    + SW'(rgg3_pkg::W_CENTER) * SW'(win_q[4])
		    + SW'(rgg3_pkg::ROUND_HALF);
	end

	// Stage 3: divide by 1000
	logic [SW-1:0]       acc_s3;
	rgg3_pkg::tap_mask_t mask_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (free3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (move2) begin
			acc_s3  <= acc;
			mask_s3 <= mask_s2;
		end
	end

	// Output register
	rgg3_pkg::out_item_t out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (move3) begin
			out_data_q.filtered  <= rgg3_pkg::div1000(acc_s3);
			out_data_q.row_end   <= mask_s3.right;
			out_data_q.frame_end <= mask_s3.right && mask_s3.bot;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ rtl/rgg3_checker.sv @@
// ----------------------------------------------------------------------------
// rgg3_checker - port-level checks for rgb_gray_gaussian3x3_unit
// Watches the stream handshakes and result flags from outside the block.
// ----------------------------------------------------------------------------
module rgg3_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input rgg3_pkg::out_item_t out_data
);

	// A stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	// Input backpressure only comes from a stalled waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	// The last pixel of a frame is also the last of its row
	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_data.frame_end || out_data.row_end))
		else $error("frame_end without row_end");

endmodule

bind rgb_gray_gaussian3x3_unit rgg3_checker u_rgg3_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

@@ verif/rgb_gray_gaussian3x3_unit_tb.sv @@
// ----------------------------------------------------------------------------
// rgb_gray_gaussian3x3_unit_tb - self-checking bench for the gray / 3x3 blur
// A queue-fed driver streams RGB frames of many shapes. A bit-accurate blur
// predictor runs on every input transfer, and a monitor checks each output
// transfer against the oldest predicted pixel. Both sides idle at random,
// and the receiver holds off long enough once to back the block up.
// ----------------------------------------------------------------------------
module rgb_gray_gaussian3x3_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Line depth and fixed-point weights (per thousand)
	localparam int LINE_DEPTH = 1024;
	localparam int Y_WR       = 299;
	localparam int Y_WG       = 587;
	localparam int Y_WB       = 114;
	localparam int K_CORNER   = 45;
	localparam int K_EDGE     = 122;
	localparam int K_MID      = 332;
	localparam int HALF_UP    = 500;

	// Run shape
	localparam int RANDOM_ITEMS  = 500;
	localparam int CALM_ITEMS    = 150;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 300;
	localparam int IDLE_LIMIT    = 4000;
	localparam int REPORT_MAX    = 10;

	// Pending work for the driver: a pixel transfer or a register write
	typedef struct packed {
		logic                            is_cfg;
		rgg3_pkg::cfg_reg_t              reg_sel;
		logic [rgg3_pkg::CFG_DATA_W-1:0] reg_val;
		rgg3_pkg::in_item_t              pix;
	} px_job_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            cfg_write = 1'b0;
	logic [rgg3_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [rgg3_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
	logic                            in_valid  = 1'b0;
	logic                            in_stall;
	rgg3_pkg::in_item_t              in_data   = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	rgg3_pkg::out_item_t             out_data;

	px_job_t             pix_pending[$];
	rgg3_pkg::out_item_t blur_expected[$];

	// Predictor state
	logic [10:0] img_width_reg;
	logic [15:0] img_height_reg;
	logic [7:0]  line_top [LINE_DEPTH];
	logic [7:0]  line_mid [LINE_DEPTH];
	logic [7:0]  win [9];
	int unsigned scan_row;
	int unsigned scan_col;

	// Bookkeeping
	int  mismatches     = 0;
	int  results_seen   = 0;
	int  items_accepted = 0;
	int  reg_writes     = 0;
	int  gap_left       = 0;
	int  stall_left     = 0;
	int  hold_left      = 0;
	int  hold_asked     = 0;
	int  hold_served    = 0;
	int  idle_cycles    = 0;
	bit  calm           = 1'b0;

	rgb_gray_gaussian3x3_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Predictor: back to reset values
	task automatic blur_reset();
		img_width_reg  = 11'd512;
		img_height_reg = 16'd512;
		scan_row = 0;
		scan_col = 0;
		for (int i = 0; i < 9; i++) win[i] = '0;
		for (int i = 0; i < LINE_DEPTH; i++) begin
			line_top[i] = '0;
			line_mid[i] = '0;
		end
	endtask

	// Predictor: one register write, which also restarts the frame
	task automatic blur_config(input rgg3_pkg::cfg_reg_t sel,
			input logic [rgg3_pkg::CFG_DATA_W-1:0] val);
		if (sel == rgg3_pkg::CFG_IMAGE_WIDTH)
			img_width_reg = val[10:0];
		else
			img_height_reg = val[15:0];
		scan_row = 0;
		scan_col = 0;
	endtask

	// Predictor: one accepted pixel, pushes the blurred pixel it completes
	task automatic blur_predict(input rgg3_pkg::in_item_t px);
		int unsigned         w, h, r, c, g, s, rc, cc, acc;
		logic [7:0]          tap [9];
		bit                  hit;
		rgg3_pkg::out_item_t res;
		w = img_width_reg;
		if (w < 1) w = 1;
		if (w > LINE_DEPTH) w = LINE_DEPTH;
		h = (img_height_reg == 0) ? 1 : img_height_reg;
		r = scan_row;
		c = scan_col;
		if (c >= w) c = w - 1;
		g = 0;
		if (px.cmd == rgg3_pkg::CMD_PIXEL) begin
			s = Y_WR * px.red + Y_WG * px.green + Y_WB * px.blue;
			g = (s + HALF_UP) / 1000;
		end

		// shift window left, new column enters on the right
		for (int i = 0; i < 3; i++) begin
			win[i*3]   = win[i*3+1];
			win[i*3+1] = win[i*3+2];
		end
		win[2] = line_top[c];
		win[5] = line_mid[c];
		win[8] = g[7:0];
		line_top[c] = line_mid[c];
		line_mid[c] = g[7:0];

		// centre completed by this pixel
		hit = 0;
		rc = 0;
		cc = 0;
		if (c >= 1 && r >= 1) begin
			hit = 1; rc = r - 1; cc = c - 1;
		end else if (c == 0 && r >= 2) begin
			hit = 1; rc = r - 2; cc = w - 1;
		end

		if (c + 1 >= w) begin
			scan_col = 0;
			scan_row = r + 1;
		end else begin
			scan_col = c + 1;
			scan_row = r;
		end

		if (hit) begin
			tap = win;
			// taps outside the image read as zero
			if (rc == 0) begin tap[0] = '0; tap[1] = '0; tap[2] = '0; end
			if (rc + 1 >= h) begin tap[6] = '0; tap[7] = '0; tap[8] = '0; end
			if (cc == 0) begin tap[0] = '0; tap[3] = '0; tap[6] = '0; end
			if (cc + 1 >= w) begin tap[2] = '0; tap[5] = '0; tap[8] = '0; end
			acc = K_CORNER * (int'(tap[0]) + int'(tap[2]) + int'(tap[6]) + int'(tap[8]))
				+ K_EDGE * (int'(tap[1]) + int'(tap[3]) + int'(tap[5]) + int'(tap[7]))
				+ K_MID * int'(tap[4]);
			acc = (acc + HALF_UP) / 1000;
			res.filtered  = acc[7:0];
			res.row_end   = (cc + 1 >= w);
			res.frame_end = (cc + 1 >= w) && (rc + 1 >= h);
			if (res.frame_end) begin
				scan_row = 0;
				scan_col = 0;
			end
			blur_expected.push_back(res);
		end
	endtask

	// Driver: presents queued jobs, predicts on every input transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			in_data   <= '0;
			cfg_write <= 1'b0;
			cfg_index <= '0;
			cfg_data  <= '0;
			gap_left  = 0;
			blur_reset();
		end else begin
			logic               nxt_valid;
			logic               nxt_cfg;
			rgg3_pkg::in_item_t nxt_pix;
			nxt_valid = in_valid;
			nxt_cfg   = 1'b0;
			nxt_pix   = in_data;
			if (in_valid && !in_stall) begin
				blur_predict(in_data);
				void'(pix_pending.pop_front());
				items_accepted++;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pix_pending.size() != 0) begin
					if (pix_pending[0].is_cfg) begin
						nxt_cfg = 1'b1;
						cfg_index <= pix_pending[0].reg_sel;
						cfg_data  <= pix_pending[0].reg_val;
						blur_config(pix_pending[0].reg_sel, pix_pending[0].reg_val);
						void'(pix_pending.pop_front());
					end else if (!calm && $urandom_range(0, 15) == 0) begin
						gap_left = $urandom_range(0, 8);
					end else begin
						nxt_valid = 1'b1;
						nxt_pix   = pix_pending[0].pix;
					end
				end
			end
			in_valid  <= nxt_valid;
			in_data   <= nxt_pix;
			cfg_write <= nxt_cfg;
		end
	end

	// Monitor: checks output transfers and drives the receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left = 0;
			hold_left  = 0;
		end else begin
			logic                nxt_stall;
			rgg3_pkg::out_item_t want;
			if (out_valid && !out_stall) begin
				results_seen++;
				if (blur_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%t: unexpected output filtered=%0d row_end=%0b frame_end=%0b",
							$realtime, out_data.filtered, out_data.row_end, out_data.frame_end);
				end else begin
					want = blur_expected.pop_front();
					if (out_data !== want) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("%t: out %0d exp/got: filtered %0d/%0d %s",
								$realtime, results_seen, want.filtered, out_data.filtered,
								$sformatf("row_end %0b/%0b frame_end %0b/%0b",
									want.row_end, out_data.row_end,
									want.frame_end, out_data.frame_end));
					end
				end
			end

			// long hold-off on request, otherwise short random bursts
			if (hold_served != hold_asked) begin
				hold_served = hold_asked;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				nxt_stall = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				nxt_stall = 1'b1;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(0, 8);
				nxt_stall  = 1'b1;
			end else begin
				nxt_stall = 1'b0;
			end
			out_stall <= nxt_stall;
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%t: no transfer for %0d cycles", $realtime, idle_cycles);
				$display("rgb_gray_gaussian3x3_unit_tb: done, errors");
				$finish;
			end
		end
	end

	// Channel value with extra weight on the extremes
	function automatic logic [7:0] rand_chan();
		case ($urandom_range(0, 7))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic push_item(input rgg3_pkg::in_item_t px);
		px_job_t job;
		job     = '0;
		job.pix = px;
		pix_pending.push_back(job);
	endtask

	// Wait until every queued transfer is taken and every result is back
	task automatic drain();
		while (pix_pending.size() != 0 || blur_expected.size() != 0) @(posedge clk);
	endtask

	// Register write with the block idle
	task automatic write_reg(input rgg3_pkg::cfg_reg_t sel, input int unsigned val);
		px_job_t job;
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		job         = '0;
		job.is_cfg  = 1'b1;
		job.reg_sel = sel;
		job.reg_val = val[rgg3_pkg::CFG_DATA_W-1:0];
		pix_pending.push_back(job);
		while (pix_pending.size() != 0) @(posedge clk);
		reg_writes++;
	endtask

	// n items laid out as a frame of w x h pixels followed by its flush tail
	task automatic send_frame(input int unsigned w, input int unsigned h,
			input int unsigned n);
		rgg3_pkg::in_item_t px;
		longint             body;
		body = longint'(w) * longint'(h);
		for (int unsigned k = 0; k < n; k++) begin
			px.red   = rand_chan();
			px.green = rand_chan();
			px.blue  = rand_chan();
			if (k < body)
				px.cmd = ($urandom_range(0, 19) == 0) ? rgg3_pkg::CMD_FLUSH : rgg3_pkg::CMD_PIXEL;
			else
				px.cmd = ($urandom_range(0, 9) == 0) ? rgg3_pkg::CMD_PIXEL : rgg3_pkg::CMD_FLUSH;
			push_item(px);
		end
	endtask

	// Stimulus
	initial begin
		int unsigned raw_w, raw_h, ew, eh, full, n;
		int unsigned random_sent;
		int          iter;
		bit          must_cfg;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 3x2 frame: channel extremes, flush inside the frame, pixel in the tail
		write_reg(rgg3_pkg::CFG_IMAGE_WIDTH, 3);
		write_reg(rgg3_pkg::CFG_IMAGE_HEIGHT, 2);
		push_item('{rgg3_pkg::CMD_PIXEL, 8'd255, 8'd255, 8'd255});
		push_item('{rgg3_pkg::CMD_PIXEL, 8'd0, 8'd0, 8'd0});
		push_item('{rgg3_pkg::CMD_PIXEL, 8'd255, 8'd0, 8'd0});
		push_item('{rgg3_pkg::CMD_PIXEL, 8'd0, 8'd255, 8'd0});
		push_item('{rgg3_pkg::CMD_PIXEL, 8'd0, 8'd0, 8'd255});
		push_item('{rgg3_pkg::CMD_FLUSH, 8'd255, 8'd255, 8'd255});
		push_item('{rgg3_pkg::CMD_PIXEL, 8'd255, 8'd255, 8'd255});
		push_item('{rgg3_pkg::CMD_FLUSH, 8'd0, 8'd0, 8'd0});
		push_item('{rgg3_pkg::CMD_FLUSH, 8'd0, 8'd0, 8'd0});
		push_item('{rgg3_pkg::CMD_FLUSH, 8'd0, 8'd0, 8'd0});

		// single pixel frame, then zero width and zero height
		write_reg(rgg3_pkg::CFG_IMAGE_WIDTH, 1);
		write_reg(rgg3_pkg::CFG_IMAGE_HEIGHT, 1);
		send_frame(1, 1, 3);
		write_reg(rgg3_pkg::CFG_IMAGE_WIDTH, 0);
		write_reg(rgg3_pkg::CFG_IMAGE_HEIGHT, 0);
		send_frame(1, 1, 3);

		// tallest frame, cut short by the next write
		write_reg(rgg3_pkg::CFG_IMAGE_WIDTH, 2);
		write_reg(rgg3_pkg::CFG_IMAGE_HEIGHT, 65535);
		send_frame(2, 65535, 6);

		// oversized width clamps to the line depth: wrap into the second row
		write_reg(rgg3_pkg::CFG_IMAGE_WIDTH, 2047);
		send_frame(LINE_DEPTH, 65535, LINE_DEPTH + 2);

		// random frames, mostly complete, some cut short or overrun
		random_sent = 0;
		iter        = 0;
		must_cfg    = 1'b1;
		ew          = 1;
		eh          = 1;
		while (random_sent < RANDOM_ITEMS) begin
			if (random_sent + CALM_ITEMS >= RANDOM_ITEMS)
				calm = 1'b1;
			if (must_cfg || iter == 5 || $urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 19))
					0:       raw_w = 0;
					1, 2, 3: raw_w = $urandom_range(1, 40);
					default: raw_w = $urandom_range(1, 10);
				endcase
				raw_h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
				if (iter == 5) begin
					raw_w = 10;
					raw_h = 6;
				end
				if ($urandom_range(0, 1)) begin
					write_reg(rgg3_pkg::CFG_IMAGE_WIDTH, raw_w);
					write_reg(rgg3_pkg::CFG_IMAGE_HEIGHT, raw_h);
				end else begin
					write_reg(rgg3_pkg::CFG_IMAGE_HEIGHT, raw_h);
					write_reg(rgg3_pkg::CFG_IMAGE_WIDTH, raw_w);
				end
				ew = (raw_w == 0) ? 1 : raw_w;
				eh = (raw_h == 0) ? 1 : raw_h;
			end
			full     = ew * eh + ew + 1;
			must_cfg = 1'b0;
			if (iter == 5) begin
				// receiver stops while this frame keeps coming
				hold_asked++;
				n = full;
			end else if ($urandom_range(0, 9) == 0) begin
				n        = $urandom_range(1, full + ew);
				must_cfg = 1'b1;
			end else begin
				n = full;
			end
			send_frame(ew, eh, n);
			random_sent += n;
			iter++;
			// occasional pause of the sender until all results are in
			if ($urandom_range(0, 7) == 0)
				drain();
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		mismatches += blur_expected.size();

		$display("covered %0d input transfers, %0d blurred pixels, %0d register writes",
			items_accepted, results_seen, reg_writes);
		$display("frames 1x1 up to 1024 wide, clamped and zero sizes, cut frames, both-side stalls");
		if (mismatches == 0) begin
			$display("rgb_gray_gaussian3x3_unit_tb: done, clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("rgb_gray_gaussian3x3_unit_tb: done, errors");
		end
		$finish;
	end

endmodule
